// File: design/first_fit_block_allocator_assert.svh
// Assertion macros for the first-fit block allocator.
// Depends on clk and rst_n being visible where the macros are used.
`ifndef FIRST_FIT_BLOCK_ALLOCATOR_ASSERT_SVH
`define FIRST_FIT_BLOCK_ALLOCATOR_ASSERT_SVH

// Implication checked on the same edge.
`define FFBA_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Implication checked on the next edge.
`define FFBA_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: design/ffba_pkg.sv
// Shared types and constants for the first-fit block allocator.
// No dependencies.
package ffba_pkg;

  localparam int CELLS_DEF   = 1024;
  localparam int MAX_REQ_DEF = 1024;
  localparam int FIELD_W     = 11;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_CHK,
    S_MARK,
    S_HWAIT,
    S_UNMARK,
    S_OUT
  } ffba_state_t;

endpackage

// File: design/first_fit_block_allocator.sv
// First-fit allocator over a row of cells numbered from 1. An allocate transaction scans the
// cell occupancy memory from cell 1, reading each cell's flag in S_SCAN and checking it in
// S_CHK, until a free run of the requested size ends, then marks the run busy one cell per
// cycle and presents the result, where it waits on out_ready. An allocate fails for a size
// of zero or above total_cells, or when the scan reaches total_cells with no free run.
// A free transaction reads the history memory and releases the cells one cell per cycle;
// it releases nothing when the entry is not live or the request number is bad.
// Both memories have one write port and one registered read port.
// After reset and after every total_cells write the block sweeps both memories, one entry a
// cycle, over max(CELLS, MAX_REQUESTS) entries, and takes no transaction meanwhile.
// Depends on ffba_pkg and first_fit_block_allocator_assert.svh.
`include "first_fit_block_allocator_assert.svh"

module first_fit_block_allocator
  import ffba_pkg::*;
#(
  parameter int CELLS        = CELLS_DEF,
  parameter int MAX_REQUESTS = MAX_REQ_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  logic [FIELD_W-1:0] cfg_wr_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_operation,
  input  logic [FIELD_W-1:0] in_block_size,
  input  logic [FIELD_W-1:0] in_request_to_free,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_found,
  output logic [FIELD_W-1:0] out_start_cell
);

  localparam int CW  = $clog2(CELLS + 1);
  localparam int W   = (CW > FIELD_W) ? CW : FIELD_W;
  localparam int AW  = $clog2(CELLS);
  localparam int HAW = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;
  localparam int RW  = $clog2(MAX_REQUESTS + 2);
  localparam int CLN = (CELLS > MAX_REQUESTS) ? CELLS : MAX_REQUESTS;
  localparam int CLW = $clog2(CLN + 1);
  localparam int HEW = 2 * W + 1;

  ffba_state_t state_r, state_nxt;

  logic [W-1:0]   total_r, total_nxt;
  logic [RW-1:0]  req_cnt_r, req_cnt_nxt;
  logic [RW-1:0]  num_r, num_nxt;
  logic [W-1:0]   blk_r, blk_nxt;
  logic [W-1:0]   cur_r, cur_nxt;
  logic [W-1:0]   run_r, run_nxt;
  logic [W-1:0]   ptr_r, ptr_nxt;
  logic [W-1:0]   cnt_r, cnt_nxt;
  logic [HAW-1:0] hva_r, hva_nxt;
  logic [CLW-1:0] clr_r, clr_nxt;
  logic           res_found_r, res_found_nxt;
  logic [W-1:0]   res_start_r, res_start_nxt;
  logic           out_valid_r, out_valid_nxt;
  logic           out_found_r, out_found_nxt;
  logic [FIELD_W-1:0] out_start_r, out_start_nxt;

  // occupancy memory: one busy flag per cell
  logic           cell_mem [CELLS];
  logic           cell_we;
  logic [AW-1:0]  cell_wa;
  logic           cell_wd;
  logic [AW-1:0]  cell_ra;
  logic           cell_rd_r;

  // history memory: {live, len, start} per request number
  logic [HEW-1:0] hist_mem [MAX_REQUESTS];
  logic           hist_we;
  logic [HAW-1:0] hist_wa;
  logic [HEW-1:0] hist_wd;
  logic [HAW-1:0] hist_ra;
  logic [HEW-1:0] hist_rd_r;

  always_ff @(posedge clk) begin
    if (cell_we) begin
      cell_mem[cell_wa] <= cell_wd;
    end
    cell_rd_r <= cell_mem[cell_ra];
    if (hist_we) begin
      hist_mem[hist_wa] <= hist_wd;
    end
    hist_rd_r <= hist_mem[hist_ra];
  end

  logic [W-1:0]  cfg_ext;
  logic [W-1:0]  cur_m1;
  logic [W-1:0]  ptr_m1;
  logic [W-1:0]  size_ext;
  logic [31:0]   victim_m1;
  logic [31:0]   num_m1;
  logic          victim_ok;
  logic          num_rec;
  logic [W-1:0]  run_inc;
  logic          h_live;
  logic [W-1:0]  h_len;
  logic [W-1:0]  h_start;

  assign cfg_ext   = W'(cfg_wr_data);
  assign size_ext  = W'(in_block_size);
  assign cur_m1    = cur_r - W'(1);
  assign ptr_m1    = ptr_r - W'(1);
  assign victim_m1 = 32'(in_request_to_free) - 32'd1;
  assign num_m1    = 32'(num_r) - 32'd1;
  assign victim_ok = (in_request_to_free != '0) &&
                     (32'(in_request_to_free) <= 32'(MAX_REQUESTS));
  assign num_rec   = 32'(num_r) <= 32'(MAX_REQUESTS);
  assign run_inc   = run_r + W'(1);
  assign h_live    = hist_rd_r[HEW-1];
  assign h_len     = hist_rd_r[2*W-1:W];
  assign h_start   = hist_rd_r[W-1:0];

  assign in_ready       = (state_r == S_IDLE);
  assign out_valid      = out_valid_r;
  assign out_found      = out_found_r;
  assign out_start_cell = out_start_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      total_r     <= W'(CELLS);
      req_cnt_r   <= '0;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      total_r     <= total_nxt;
      req_cnt_r   <= req_cnt_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
    end
    num_r       <= num_nxt;
    blk_r       <= blk_nxt;
    cur_r       <= cur_nxt;
    run_r       <= run_nxt;
    ptr_r       <= ptr_nxt;
    cnt_r       <= cnt_nxt;
    hva_r       <= hva_nxt;
    res_found_r <= res_found_nxt;
    res_start_r <= res_start_nxt;
    out_found_r <= out_found_nxt;
    out_start_r <= out_start_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    total_nxt     = total_r;
    req_cnt_nxt   = req_cnt_r;
    num_nxt       = num_r;
    blk_nxt       = blk_r;
    cur_nxt       = cur_r;
    run_nxt       = run_r;
    ptr_nxt       = ptr_r;
    cnt_nxt       = cnt_r;
    hva_nxt       = hva_r;
    clr_nxt       = clr_r;
    res_found_nxt = res_found_r;
    res_start_nxt = res_start_r;
    out_valid_nxt = out_valid_r;
    out_found_nxt = out_found_r;
    out_start_nxt = out_start_r;

    cell_we = 1'b0;
    cell_wa = ptr_m1[AW-1:0];
    cell_wd = 1'b0;
    cell_ra = cur_m1[AW-1:0];
    hist_we = 1'b0;
    hist_wa = hva_r;
    hist_wd = '0;
    hist_ra = victim_m1[HAW-1:0];

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_CLEAR: begin
        cell_wa = AW'(clr_r);
        hist_wa = HAW'(clr_r);
        cell_we = (32'(clr_r) < 32'(CELLS));
        hist_we = (32'(clr_r) < 32'(MAX_REQUESTS));
        clr_nxt = clr_r + CLW'(1);
        if (32'(clr_r) == 32'(CLN - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          if (32'(req_cnt_r) <= 32'(MAX_REQUESTS)) begin
            req_cnt_nxt = req_cnt_r + RW'(1);
            num_nxt     = req_cnt_r + RW'(1);
          end else begin
            num_nxt = req_cnt_r;
          end
          if (in_operation == OP_ALLOC) begin
            blk_nxt = size_ext;
            cur_nxt = W'(1);
            run_nxt = '0;
            if (in_block_size == '0 || size_ext > total_r) begin
              res_found_nxt = 1'b0;
              res_start_nxt = '0;
              state_nxt     = S_OUT;
            end else begin
              state_nxt = S_SCAN;
            end
          end else if (victim_ok) begin
            hva_nxt   = victim_m1[HAW-1:0];
            state_nxt = S_HWAIT;
          end
        end
      end
      S_SCAN: begin
        // read issued at cur_r - 1; flag is checked next cycle
        state_nxt = S_CHK;
      end
      S_CHK: begin
        run_nxt = cell_rd_r ? '0 : run_inc;
        if (!cell_rd_r && run_inc == blk_r) begin
          ptr_nxt       = cur_r - blk_r + W'(1);
          cnt_nxt       = blk_r;
          res_start_nxt = cur_r - blk_r + W'(1);
          state_nxt     = S_MARK;
        end else if (cur_r == total_r) begin
          res_found_nxt = 1'b0;
          res_start_nxt = '0;
          state_nxt     = S_OUT;
        end else begin
          cur_nxt   = cur_r + W'(1);
          state_nxt = S_SCAN;
        end
      end
      S_MARK: begin
        cell_we = 1'b1;
        cell_wd = 1'b1;
        ptr_nxt = ptr_r + W'(1);
        cnt_nxt = cnt_r - W'(1);
        if (cnt_r == W'(1)) begin
          hist_we       = num_rec;
          hist_wa       = num_m1[HAW-1:0];
          hist_wd       = {1'b1, blk_r, res_start_r};
          res_found_nxt = 1'b1;
          state_nxt     = S_OUT;
        end
      end
      S_HWAIT: begin
        if (h_live) begin
          hist_we   = 1'b1;
          hist_wd   = {1'b0, h_len, h_start};
          ptr_nxt   = h_start;
          cnt_nxt   = h_len;
          state_nxt = S_UNMARK;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_UNMARK: begin
        cell_we = 1'b1;
        ptr_nxt = ptr_r + W'(1);
        cnt_nxt = cnt_r - W'(1);
        if (cnt_r == W'(1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_OUT: begin
        // hold until the output register is free
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_found_nxt = res_found_r;
          out_start_nxt = res_start_r[FIELD_W-1:0];
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLEAR;
        clr_nxt   = '0;
      end
    endcase

    // a write to total_cells restarts request numbering with a clearing sweep
    if (cfg_wr_en) begin
      if (cfg_ext == '0) begin
        total_nxt = W'(1);
      end else if (32'(cfg_ext) > 32'(CELLS)) begin
        total_nxt = W'(CELLS);
      end else begin
        total_nxt = cfg_ext;
      end
      req_cnt_nxt = '0;
      clr_nxt     = '0;
      state_nxt   = S_CLEAR;
    end
  end

  `FFBA_NEXT(a_out_hold, out_valid_r && !out_ready, out_valid_r, "result dropped while stalled")
  `FFBA_IMPLY(a_mark_range, state_r == S_MARK, ptr_r >= W'(1) && ptr_r <= total_r, "mark outside cells")
  `FFBA_IMPLY(a_run_bound, state_r == S_CHK, run_r < blk_r, "run count passed requested size")
  `FFBA_IMPLY(a_scan_bound, state_r == S_SCAN, cur_r >= W'(1) && cur_r <= total_r, "scan outside cells")

endmodule
